// ----- rtl/core/mvt_pkg.sv -----
package mvt_pkg;

   localparam int ELEM_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int NUM_LANES      = 4;
   localparam int COL_BITS       = 2;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_XFORM = 1'b1
   } cmd_type;

   typedef struct packed {
      logic                valid;
      cmd_type             cmd;
      logic [COL_BITS-1:0] col;
   } ctl_type;

endpackage

// ----- rtl/core/mat4_vec4_transform.sv -----
// 4x4 matrix times 4-vector transform, signed fixed point (Q16.16 by default).
// request channel: req_command selects a column load or a transform; a load
// writes req_elem0..3 into matrix column req_column and returns no item, a
// transform carries the vector (x, y, z, w) in req_elem0..3.
// response channel: rsp_out0..3 are the saturated components of the product,
// rsp_saturated is set when any component was clipped.
// the matrix lives in a row of four column cells; each item walks the row,
// a cell multiplies its column by its vector component and adds the products
// to the running sums, and a load updates a cell when it passes through it,
// so every item sees exactly the loads that were accepted before it.
// pipeline: two registered stages per cell, then one for shift and saturate.
// throughput: one item per cycle as long as the receiver takes each result.
// reset clears the matrix to zero and empties the pipeline.
// when the receiver stalls, the result waits in the output register while
// items keep entering until every stage ahead of them is full; req_ready then
// drops and resumes as soon as the result is taken.
module mat4_vec4_transform #(
   parameter int ELEM_WIDTH = mvt_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_command,
   input  logic [mvt_pkg::COL_BITS-1:0] req_column,
   input  logic signed [ELEM_WIDTH-1:0] req_elem0,
   input  logic signed [ELEM_WIDTH-1:0] req_elem1,
   input  logic signed [ELEM_WIDTH-1:0] req_elem2,
   input  logic signed [ELEM_WIDTH-1:0] req_elem3,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [ELEM_WIDTH-1:0] rsp_out0,
   output logic signed [ELEM_WIDTH-1:0] rsp_out1,
   output logic signed [ELEM_WIDTH-1:0] rsp_out2,
   output logic signed [ELEM_WIDTH-1:0] rsp_out3,
   output logic                         rsp_saturated
);

   localparam int SUM_W = 2*ELEM_WIDTH+2;
   localparam int LANES = mvt_pkg::NUM_LANES;

   mvt_pkg::ctl_type                 ctl_chain [LANES+1];
   logic                             rdy_chain [LANES+1];
   logic [LANES-1:0][ELEM_WIDTH-1:0] vec_chain [LANES+1];
   logic [LANES-1:0][SUM_W-1:0]      sum_chain [LANES+1];
   logic [LANES-1:0][ELEM_WIDTH-1:0] rsp_data;

   assign ctl_chain[0].valid = req_valid;
   assign ctl_chain[0].cmd   = mvt_pkg::cmd_type'(req_command);
   assign ctl_chain[0].col   = req_column;
   assign vec_chain[0]       = {req_elem3, req_elem2, req_elem1, req_elem0};
   assign sum_chain[0]       = '0;
   assign req_ready          = rdy_chain[0];

   for (genvar j = 0; j < LANES; j++) begin : g_cell
      mvt_cell #(
         .ELEM_WIDTH (ELEM_WIDTH),
         .COL_INDEX  (j)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_ctl    (ctl_chain[j]),
         .in_ready  (rdy_chain[j]),
         .in_vec    (vec_chain[j]),
         .in_sum    (sum_chain[j]),
         .out_ctl   (ctl_chain[j+1]),
         .out_ready (rdy_chain[j+1]),
         .out_vec   (vec_chain[j+1]),
         .out_sum   (sum_chain[j+1])
      );
   end

   mvt_sat #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_sat (
      .clock         (clock),
      .reset         (reset),
      .in_ctl        (ctl_chain[LANES]),
      .in_ready      (rdy_chain[LANES]),
      .in_sum        (sum_chain[LANES]),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .rsp_saturated (rsp_saturated)
   );

   assign rsp_out0 = rsp_data[0];
   assign rsp_out1 = rsp_data[1];
   assign rsp_out2 = rsp_data[2];
   assign rsp_out3 = rsp_data[3];

endmodule

// ----- rtl/core/mvt_cell.sv -----
module mvt_cell #(
   parameter int ELEM_WIDTH = mvt_pkg::ELEM_WIDTH_DEF,
   parameter int COL_INDEX  = 0
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  mvt_pkg::ctl_type                                  in_ctl,
   output logic                                              in_ready,
   input  logic [mvt_pkg::NUM_LANES-1:0][ELEM_WIDTH-1:0]     in_vec,
   input  logic [mvt_pkg::NUM_LANES-1:0][2*ELEM_WIDTH+1:0]   in_sum,
   output mvt_pkg::ctl_type                                  out_ctl,
   input  logic                                              out_ready,
   output logic [mvt_pkg::NUM_LANES-1:0][ELEM_WIDTH-1:0]     out_vec,
   output logic [mvt_pkg::NUM_LANES-1:0][2*ELEM_WIDTH+1:0]   out_sum
);

   localparam int SUM_W  = 2*ELEM_WIDTH+2;
   localparam int PROD_W = 2*ELEM_WIDTH;
   localparam int LANES  = mvt_pkg::NUM_LANES;

   logic [LANES-1:0][ELEM_WIDTH-1:0] col_ff;

   mvt_pkg::ctl_type                 a_ctl_ff;
   logic [LANES-1:0][ELEM_WIDTH-1:0] a_vec_ff;
   logic [LANES-1:0][SUM_W-1:0]      a_sum_ff;
   logic [LANES-1:0][PROD_W-1:0]     a_prod_ff;
   logic [LANES-1:0][PROD_W-1:0]     a_prod_in;

   mvt_pkg::ctl_type                 b_ctl_ff;
   logic [LANES-1:0][ELEM_WIDTH-1:0] b_vec_ff;
   logic [LANES-1:0][SUM_W-1:0]      b_sum_ff;
   logic [LANES-1:0][SUM_W-1:0]      b_sum_in;

   logic a_ready;
   logic b_ready;
   logic col_write;

   assign b_ready  = !b_ctl_ff.valid || out_ready;
   assign a_ready  = !a_ctl_ff.valid || b_ready;
   assign in_ready = a_ready;

   assign col_write = in_ctl.valid && a_ready && (in_ctl.cmd == mvt_pkg::CMD_LOAD)
                      && (in_ctl.col == mvt_pkg::COL_BITS'(COL_INDEX));

   // one column element times this cell's vector component, per row
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         a_prod_in[k] = $signed(col_ff[k]) * $signed(in_vec[COL_INDEX]);
      end
   end

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         b_sum_in[k] = $signed(a_sum_ff[k]) + SUM_W'($signed(a_prod_ff[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (col_write) begin
         col_ff <= in_vec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
         b_ctl_ff <= '0;
      end else begin
         if (a_ready) begin
            a_ctl_ff <= in_ctl;
         end
         if (b_ready) begin
            b_ctl_ff <= a_ctl_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_vec_ff  <= in_vec;
         a_sum_ff  <= in_sum;
         a_prod_ff <= a_prod_in;
      end
      if (b_ready) begin
         b_vec_ff <= a_vec_ff;
         b_sum_ff <= b_sum_in;
      end
   end

   assign out_ctl = b_ctl_ff;
   assign out_vec = b_vec_ff;
   assign out_sum = b_sum_ff;

endmodule

// ----- rtl/core/mvt_sat.sv -----
module mvt_sat #(
   parameter int ELEM_WIDTH = mvt_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  mvt_pkg::ctl_type                                 in_ctl,
   output logic                                             in_ready,
   input  logic [mvt_pkg::NUM_LANES-1:0][2*ELEM_WIDTH+1:0]  in_sum,
   output logic                                             rsp_valid,
   input  logic                                             rsp_ready,
   output logic [mvt_pkg::NUM_LANES-1:0][ELEM_WIDTH-1:0]    rsp_data,
   output logic                                             rsp_saturated
);

   localparam int SUM_W = 2*ELEM_WIDTH+2;
   localparam int HI_W  = SUM_W-ELEM_WIDTH+1;
   localparam int LANES = mvt_pkg::NUM_LANES;

   logic                             valid_ff;
   logic [LANES-1:0][ELEM_WIDTH-1:0] data_ff;
   logic [LANES-1:0][ELEM_WIDTH-1:0] data_in;
   logic                             sat_ff;
   logic                             sat_in;
   logic                             take;

   assign in_ready = !valid_ff || rsp_ready;
   assign take     = in_ctl.valid && in_ready;

   always_comb begin
      logic signed [SUM_W-1:0] shifted;
      logic [HI_W-1:0]         hi;
      sat_in = 1'b0;
      for (int k = 0; k < LANES; k++) begin
         shifted = $signed(in_sum[k]) >>> FRAC_BITS;
         hi      = shifted[SUM_W-1:ELEM_WIDTH-1];
         if ((&hi) || !(|hi)) begin
            data_in[k] = shifted[ELEM_WIDTH-1:0];
         end else begin
            sat_in = 1'b1;
            if (shifted[SUM_W-1]) begin
               data_in[k] = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
            end else begin
               data_in[k] = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         // load items end here without a result
         valid_ff <= take && (in_ctl.cmd == mvt_pkg::CMD_XFORM);
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_data      = data_ff;
   assign rsp_saturated = sat_ff;

endmodule

// ----- verif/mat4_vec4_transform_tb.sv -----
`timescale 1ns / 1ps

module mat4_vec4_transform_tb;

   localparam int EW           = mvt_pkg::ELEM_WIDTH_DEF;
   localparam int FB           = mvt_pkg::FRAC_BITS_DEF;
   localparam int LANES        = mvt_pkg::NUM_LANES;
   localparam int SUM_W        = 2 * EW + 2;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int LONG_HOLD    = 150;

   localparam logic signed [EW-1:0]    ELEM_MAX = {1'b0, {(EW-1){1'b1}}};
   localparam logic signed [EW-1:0]    ELEM_MIN = {1'b1, {(EW-1){1'b0}}};
   localparam logic signed [EW-1:0]    UNIT     = EW'(1) << FB;
   localparam logic signed [SUM_W-1:0] SUM_MAX  = ELEM_MAX;
   localparam logic signed [SUM_W-1:0] SUM_MIN  = ELEM_MIN;

   typedef logic signed [EW-1:0] elem_type;
   typedef logic [LANES-1:0][EW-1:0] quad_type;

   typedef struct packed {
      quad_type comp;
      logic     clip;
   } xform_result_type;

   logic                         clock         = 1'b0;
   logic                         reset         = 1'b1;
   logic                         req_valid     = 1'b0;
   logic                         req_ready;
   logic                         req_command   = 1'b0;
   logic [mvt_pkg::COL_BITS-1:0] req_column    = '0;
   elem_type                     req_elem0     = '0;
   elem_type                     req_elem1     = '0;
   elem_type                     req_elem2     = '0;
   elem_type                     req_elem3     = '0;
   logic                         rsp_valid;
   logic                         rsp_ready     = 1'b1;
   elem_type                     rsp_out0;
   elem_type                     rsp_out1;
   elem_type                     rsp_out2;
   elem_type                     rsp_out3;
   logic                         rsp_saturated;

   elem_type         model_matrix [LANES][LANES];  // [column][row]
   xform_result_type pending_results [$];
   bit               sender_idle   = 1'b0;
   bit               receiver_idle = 1'b0;
   int               hold_cycles   = 0;
   int               error_count   = 0;
   int               cycle_count   = 0;

   mat4_vec4_transform i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_column    (req_column),
      .req_elem0     (req_elem0),
      .req_elem1     (req_elem1),
      .req_elem2     (req_elem2),
      .req_elem3     (req_elem3),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out0      (rsp_out0),
      .rsp_out1      (rsp_out1),
      .rsp_out2      (rsp_out2),
      .rsp_out3      (rsp_out3),
      .rsp_saturated (rsp_saturated)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("mat4_vec4_transform_tb: errors");
         $finish;
      end
   end

   initial begin
      for (int c = 0; c < LANES; c++) begin
         for (int r = 0; r < LANES; r++) begin
            model_matrix[c][r] = '0;
         end
      end
   end

   // full precision sums, floor shift, clip to element range
   function automatic xform_result_type apply_matrix(input quad_type vec);
      xform_result_type        res;
      logic signed [SUM_W-1:0] acc;
      res.clip = 1'b0;
      for (int k = 0; k < LANES; k++) begin
         acc = '0;
         for (int j = 0; j < LANES; j++) begin
            acc = acc + model_matrix[j][k] * $signed(vec[j]);
         end
         acc = acc >>> FB;
         if (acc > SUM_MAX) begin
            res.comp[k] = ELEM_MAX;
            res.clip = 1'b1;
         end else if (acc < SUM_MIN) begin
            res.comp[k] = ELEM_MIN;
            res.clip = 1'b1;
         end else begin
            res.comp[k] = acc[EW-1:0];
         end
      end
      return res;
   endfunction

   function automatic quad_type vec4(input elem_type a, input elem_type b,
                                     input elem_type c, input elem_type d);
      return {d, c, b, a};
   endfunction

   function automatic elem_type rand_elem();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return EW'($urandom_range(0, 'h3ffff)) - EW'('h20000);
         4, 5:       return $urandom;
         6:          return ELEM_MAX;
         7:          return ELEM_MIN;
         8:          return '0;
         default:    return $urandom_range(0, 1) ? UNIT : -UNIT;
      endcase
   endfunction

   function automatic quad_type rand_quad();
      return vec4(rand_elem(), rand_elem(), rand_elem(), rand_elem());
   endfunction

   task automatic report_mismatch(input string what, input logic [EW-1:0] got,
                                  input logic [EW-1:0] want);
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
      error_count++;
   endtask

   task automatic send_item(input mvt_pkg::cmd_type cmd,
                            input logic [mvt_pkg::COL_BITS-1:0] col,
                            input quad_type data);
      int gap;
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_column  <= col;
      req_elem0   <= data[0];
      req_elem1   <= data[1];
      req_elem2   <= data[2];
      req_elem3   <= data[3];
      do @(posedge clock); while (!req_ready);
      if (cmd == mvt_pkg::CMD_LOAD) begin
         for (int r = 0; r < LANES; r++) begin
            model_matrix[col][r] = data[r];
         end
      end else begin
         pending_results.push_back(apply_matrix(data));
      end
      if (sender_idle && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin : drive_rsp_ready
      int n;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            n = hold_cycles;
            hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (receiver_idle && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 17);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_results
      xform_result_type want;
      quad_type         got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_out3, rsp_out2, rsp_out1, rsp_out0};
         if (pending_results.size() == 0) begin
            report_mismatch("item with none pending, out0", got[0], '0);
         end else begin
            want = pending_results.pop_front();
            for (int k = 0; k < LANES; k++) begin
               if (got[k] !== want.comp[k]) begin
                  report_mismatch($sformatf("out%0d", k), got[k], want.comp[k]);
               end
            end
            if (rsp_saturated !== want.clip) begin
               report_mismatch("saturated", EW'(rsp_saturated), EW'(want.clip));
            end
         end
      end
   end

   task automatic test_reset_clears_matrix();
      send_item(mvt_pkg::CMD_XFORM, 2'd0, vec4(ELEM_MAX, ELEM_MIN, UNIT, -UNIT));
   endtask

   task automatic test_identity();
      for (int c = 0; c < LANES; c++) begin
         send_item(mvt_pkg::CMD_LOAD, mvt_pkg::COL_BITS'(c),
                   vec4(c == 0 ? UNIT : '0, c == 1 ? UNIT : '0,
                        c == 2 ? UNIT : '0, c == 3 ? UNIT : '0));
      end
      send_item(mvt_pkg::CMD_XFORM, 2'd3, vec4(ELEM_MAX, ELEM_MIN, '0, -1));
      send_item(mvt_pkg::CMD_XFORM, 2'd1, vec4(UNIT, -UNIT, 12345, -99999));
      send_item(mvt_pkg::CMD_XFORM, 2'd2, vec4(1, -1, ELEM_MIN, ELEM_MAX));
   endtask

   // first vector: lane 0 and 1 clip high and low, lane 2 fits, lane 3 floors negative
   task automatic test_saturation();
      for (int c = 0; c < LANES; c++) begin
         send_item(mvt_pkg::CMD_LOAD, mvt_pkg::COL_BITS'(c),
                   vec4(ELEM_MAX, ELEM_MIN, UNIT, -1));
      end
      send_item(mvt_pkg::CMD_XFORM, 2'd0, vec4(ELEM_MAX, '0, '0, '0));
      send_item(mvt_pkg::CMD_XFORM, 2'd0, vec4(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
      send_item(mvt_pkg::CMD_XFORM, 2'd0, vec4(-1, -1, -1, -1));
   endtask

   task automatic test_column_select();
      elem_type e [LANES];
      for (int c = 0; c < LANES; c++) begin
         for (int r = 0; r < LANES; r++) begin
            e[r] = EW'(4 * c + r + 1) <<< FB;
         end
         send_item(mvt_pkg::CMD_LOAD, mvt_pkg::COL_BITS'(c),
                   vec4(e[0], e[1], e[2], -e[3]));
      end
      for (int c = 0; c < LANES; c++) begin
         send_item(mvt_pkg::CMD_XFORM, mvt_pkg::COL_BITS'($urandom_range(0, 3)),
                   vec4(c == 0 ? UNIT : '0, c == 1 ? UNIT : '0,
                        c == 2 ? UNIT : '0, c == 3 ? UNIT : '0));
      end
   endtask

   task automatic test_output_backpressure();
      sender_idle = 1'b0;
      receiver_idle = 1'b0;
      hold_cycles = LONG_HOLD;
      for (int i = 0; i < 40; i++) begin
         send_item($urandom_range(0, 7) == 0 ? mvt_pkg::CMD_LOAD : mvt_pkg::CMD_XFORM,
                   mvt_pkg::COL_BITS'($urandom_range(0, 3)), rand_quad());
      end
   endtask

   task automatic test_random_stream();
      for (int chunk = 0; chunk < 13; chunk++) begin
         sender_idle = ($urandom_range(0, 3) != 0);
         receiver_idle = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < 100; i++) begin
            send_item($urandom_range(0, 3) == 0 ? mvt_pkg::CMD_LOAD : mvt_pkg::CMD_XFORM,
                      mvt_pkg::COL_BITS'($urandom_range(0, 3)), rand_quad());
         end
      end
   endtask

   task automatic test_full_rate_tail();
      sender_idle = 1'b0;
      receiver_idle = 1'b0;
      for (int i = 0; i < 200; i++) begin
         send_item($urandom_range(0, 3) == 0 ? mvt_pkg::CMD_LOAD : mvt_pkg::CMD_XFORM,
                   mvt_pkg::COL_BITS'($urandom_range(0, 3)), rand_quad());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_clears_matrix();
      test_identity();
      test_saturation();
      test_column_select();
      test_output_backpressure();
      test_random_stream();
      test_full_rate_tail();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("mat4_vec4_transform_tb: clean");
      end else begin
         $display("mat4_vec4_transform_tb: errors");
      end
      $finish;
   end

endmodule
